// ===== rtl/chull_pkg.sv =====
`timescale 1ns / 1ps

package chull_pkg;

    typedef logic [3:0] state_t;

    localparam state_t ST_LOAD  = 4'd0;
    localparam state_t ST_START = 4'd1;
    localparam state_t ST_H_RD  = 4'd2;
    localparam state_t ST_H_RDW = 4'd3;
    localparam state_t ST_MUL1  = 4'd4;
    localparam state_t ST_MUL2  = 4'd5;
    localparam state_t ST_CMP   = 4'd6;
    localparam state_t ST_POPW  = 4'd7;
    localparam state_t ST_PUSH  = 4'd8;
    localparam state_t ST_E_RD  = 4'd9;
    localparam state_t ST_E_LD  = 4'd10;

endpackage

// ===== rtl/convex_hull_monotone_chain.sv =====
// Points are taken one item per cycle; s_tready drops after the item flagged last.
// A set-up state, then, for three or more points, hull passes: each point visit and pass
// reads the point and pushes it; a cross product adds a two-step product and a compare;
// each popped vertex adds a re-read, product and compare. Each vertex is read and then
// loaded into the output register when free; points are taken again once the last is.
// aresetn (synchronous) clears counts, flags and sequencer; RAMs are not cleared.
`timescale 1ns / 1ps

module convex_hull_monotone_chain #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 24,
    localparam int PT_W      = 2 * COORD_BITS,
    localparam int TD_W      = ((PT_W + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [TD_W-1:0] s_tdata,   // x_coord, y_coord, zero pad
    input  logic            s_tlast,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [TD_W-1:0] m_tdata,   // vertex_x, vertex_y, zero pad
    output logic            m_tlast,
    output logic            m_tuser    // overflow
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int PI_W  = $clog2(MAX_POINTS);
    localparam int SC_W  = $clog2(2 * MAX_POINTS);
    localparam int D_W   = COORD_BITS + 1;
    localparam int P_W   = 2 * D_W;

    chull_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [SC_W-1:0]  sc_reg, sc_next;
    logic [SC_W-1:0]  lim_reg, lim_next;
    logic [PI_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0] ecnt_reg, ecnt_next;
    logic             upper_reg, upper_next;
    logic             src_reg, src_next;
    logic             out_valid_reg, out_valid_next;

    logic [PT_W-1:0]       prev_reg, prev_next;
    logic [PT_W-1:0]       c_reg, c_next;
    logic [PT_W-1:0]       top_reg, top_next;
    logic [PT_W-1:0]       sec_reg, sec_next;
    logic signed [P_W-1:0] p1_reg, p1_next;
    logic signed [P_W-1:0] p2_reg, p2_next;
    logic [PT_W-1:0]       out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic [PT_W-1:0] in_pt;
    logic            in_acc;
    logic            dup;
    logic            full;
    logic            st_we;
    logic [PT_W-1:0] st_rdata;
    logic            sk_we;
    logic [SC_W-1:0] sk_raddr;
    logic [PT_W-1:0] sk_rdata;
    logic            emit_last;
    logic            out_free;

    logic signed [COORD_BITS-1:0] tx, ty, sx, sy, cx, cy;
    logic signed [D_W-1:0]        mul_a, mul_b;
    logic signed [P_W-1:0]        prod;

    assign in_pt  = s_tdata[PT_W-1:0];
    assign in_acc = s_tvalid && s_tready;
    assign dup    = (count_reg != '0) && (prev_reg == in_pt);
    assign full   = count_reg >= CNT_W'(MAX_POINTS);
    assign st_we  = in_acc && !dup && !full;
    assign sk_we  = state_reg == chull_pkg::ST_PUSH;

    assign sk_raddr = (state_reg == chull_pkg::ST_E_RD || state_reg == chull_pkg::ST_E_LD)
                    ? SC_W'(idx_reg) : sc_reg - SC_W'(3);

    chull_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (count_reg[PI_W-1:0]),
        .wdata (in_pt),
        .raddr (idx_reg),
        .rdata (st_rdata)
    );

    chull_ram #(.WIDTH(PT_W), .DEPTH(2 * MAX_POINTS)) u_stack_ram (
        .aclk  (aclk),
        .we    (sk_we),
        .waddr (sc_reg),
        .wdata (c_reg),
        .raddr (sk_raddr),
        .rdata (sk_rdata)
    );

    // shared cross-product multiplier
    assign tx = top_reg[COORD_BITS-1:0];
    assign ty = top_reg[PT_W-1:COORD_BITS];
    assign sx = sec_reg[COORD_BITS-1:0];
    assign sy = sec_reg[PT_W-1:COORD_BITS];
    assign cx = c_reg[COORD_BITS-1:0];
    assign cy = c_reg[PT_W-1:COORD_BITS];

    always_comb begin
        if (state_reg == chull_pkg::ST_MUL1) begin
            mul_a = D_W'(tx) - D_W'(sx);
            mul_b = D_W'(cy) - D_W'(sy);
        end else begin
            mul_a = D_W'(ty) - D_W'(sy);
            mul_b = D_W'(cx) - D_W'(sx);
        end
        prod = P_W'(mul_a) * P_W'(mul_b);
    end

    assign emit_last = (CNT_W'(idx_reg) + CNT_W'(1)) == ecnt_reg;
    assign out_free  = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        sc_next        = sc_reg;
        lim_next       = lim_reg;
        idx_next       = idx_reg;
        ecnt_next      = ecnt_reg;
        upper_next     = upper_reg;
        src_next       = src_reg;
        out_valid_next = (out_valid_reg && m_tready) ? 1'b0 : out_valid_reg;
        prev_next      = prev_reg;
        c_next         = c_reg;
        top_next       = top_reg;
        sec_next       = sec_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            chull_pkg::ST_LOAD: begin
                if (in_acc) begin
                    if (st_we) begin
                        count_next = count_reg + CNT_W'(1);
                        prev_next  = in_pt;
                    end else if (!dup) begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = chull_pkg::ST_START;
                    end
                end
            end
            chull_pkg::ST_START: begin
                idx_next = '0;
                if (count_reg < CNT_W'(3)) begin
                    src_next   = 1'b0;
                    ecnt_next  = count_reg;
                    state_next = chull_pkg::ST_E_RD;
                end else begin
                    sc_next    = '0;
                    upper_next = 1'b0;
                    lim_next   = SC_W'(2);
                    state_next = chull_pkg::ST_H_RD;
                end
            end
            chull_pkg::ST_H_RD: begin
                state_next = chull_pkg::ST_H_RDW;
            end
            chull_pkg::ST_H_RDW: begin
                c_next     = st_rdata;
                state_next = (sc_reg >= lim_reg) ? chull_pkg::ST_MUL1 : chull_pkg::ST_PUSH;
            end
            chull_pkg::ST_MUL1: begin
                p1_next    = prod;
                state_next = chull_pkg::ST_MUL2;
            end
            chull_pkg::ST_MUL2: begin
                p2_next    = prod;
                state_next = chull_pkg::ST_CMP;
            end
            chull_pkg::ST_CMP: begin
                if (p1_reg <= p2_reg) begin
                    sc_next    = sc_reg - SC_W'(1);
                    top_next   = sec_reg;
                    state_next = chull_pkg::ST_POPW;
                end else begin
                    state_next = chull_pkg::ST_PUSH;
                end
            end
            chull_pkg::ST_POPW: begin
                sec_next   = sk_rdata;
                state_next = (sc_reg >= lim_reg) ? chull_pkg::ST_MUL1 : chull_pkg::ST_PUSH;
            end
            chull_pkg::ST_PUSH: begin
                sc_next    = sc_reg + SC_W'(1);
                sec_next   = top_reg;
                top_next   = c_reg;
                state_next = chull_pkg::ST_H_RD;
                if (!upper_reg) begin
                    if (idx_reg == PI_W'(count_reg - CNT_W'(1))) begin
                        upper_next = 1'b1;
                        lim_next   = sc_reg + SC_W'(2);
                        idx_next   = PI_W'(count_reg - CNT_W'(2));
                    end else begin
                        idx_next = idx_reg + PI_W'(1);
                    end
                end else if (idx_reg == '0) begin
                    src_next   = 1'b1;
                    ecnt_next  = (sc_reg > SC_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                              : CNT_W'(sc_reg);
                    state_next = chull_pkg::ST_E_RD;
                end else begin
                    idx_next = idx_reg - PI_W'(1);
                end
            end
            chull_pkg::ST_E_RD: begin
                state_next = chull_pkg::ST_E_LD;
            end
            chull_pkg::ST_E_LD: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = src_reg ? sk_rdata : st_rdata;
                    out_last_next  = emit_last;
                    out_ovf_next   = ovf_reg;
                    if (emit_last) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        sc_next    = '0;
                        state_next = chull_pkg::ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + PI_W'(1);
                        state_next = chull_pkg::ST_E_RD;
                    end
                end
            end
            default: begin
                state_next = chull_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= chull_pkg::ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            sc_reg        <= '0;
            lim_reg       <= '0;
            idx_reg       <= '0;
            ecnt_reg      <= '0;
            upper_reg     <= 1'b0;
            src_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            sc_reg        <= sc_next;
            lim_reg       <= lim_next;
            idx_reg       <= idx_next;
            ecnt_reg      <= ecnt_next;
            upper_reg     <= upper_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg     <= prev_next;
        c_reg        <= c_next;
        top_reg      <= top_next;
        sec_reg      <= sec_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign s_tready = state_reg == chull_pkg::ST_LOAD;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TD_W'(out_data_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

`ifndef SYNTHESIS
    a_stop_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("point item taken after the last point of a set");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == chull_pkg::ST_E_LD && out_valid_reg && !m_tready
        |=> $stable(idx_reg) && state_reg == chull_pkg::ST_E_LD)
        else $error("vertex sequencer moved on while output register busy");
`endif

endmodule

// ===== rtl/chull_ram.sv =====
`timescale 1ns / 1ps

module chull_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/convex_hull_monotone_chain_tb.sv =====
`timescale 1ns / 1ps

module convex_hull_monotone_chain_tb;

    localparam int MAX_POINTS  = 64;
    localparam int COORD_BITS  = 24;
    localparam int TD_W        = 48;
    localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN   = -COORD_MAX - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 24;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } point_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
        logic                         ovf;
    } vertex_t;

    typedef enum int {SPREAD_FULL, SPREAD_TIGHT, SPREAD_MID, SPREAD_CORNERS} spread_t;

    class hull_scoreboard;
        point_t  store[MAX_POINTS];
        int      n_stored;
        bit      ovf;
        vertex_t hull_q[$];
        int      n_errors;
        int      n_vertices;
        int      n_points;
        int      n_sets;
        int      n_ovf_sets;

        // (b-a) x (c-a) <= 0: clockwise or straight
        function bit not_left_turn(point_t a, point_t b, point_t c);
            longint abx, aby, acx, acy;
            abx = longint'($signed(b.x)) - longint'($signed(a.x));
            aby = longint'($signed(b.y)) - longint'($signed(a.y));
            acx = longint'($signed(c.x)) - longint'($signed(a.x));
            acy = longint'($signed(c.y)) - longint'($signed(a.y));
            return abx * acy <= aby * acx;
        endfunction

        function void build_hull();
            point_t  stk[2*MAX_POINTS];
            int      top;
            int      floor_lvl;
            int      cnt;
            vertex_t v;
            if (ovf)
                n_ovf_sets++;
            if (n_stored < 3) begin
                for (int i = 0; i < n_stored; i++) begin
                    v = {store[i].x, store[i].y, 1'(i + 1 == n_stored), ovf};
                    hull_q.insert(hull_q.size(), v);
                end
                return;
            end
            top = 0;
            for (int i = 0; i < n_stored; i++) begin
                while (top >= 2 && not_left_turn(stk[top-2], stk[top-1], store[i]))
                    top--;
                stk[top] = store[i];
                top++;
            end
            floor_lvl = top + 1;
            for (int i = n_stored - 2; i >= 0; i--) begin
                while (top >= floor_lvl && not_left_turn(stk[top-2], stk[top-1], store[i]))
                    top--;
                stk[top] = store[i];
                top++;
            end
            cnt = top - 1;
            if (cnt > MAX_POINTS)
                cnt = MAX_POINTS;
            for (int i = 0; i < cnt; i++) begin
                v = {stk[i].x, stk[i].y, 1'(i + 1 == cnt), ovf};
                hull_q.insert(hull_q.size(), v);
            end
        endfunction

        function void note_point(point_t p, bit last);
            n_points++;
            if (!(n_stored > 0 && store[n_stored-1] == p)) begin
                if (n_stored >= MAX_POINTS) begin
                    ovf = 1'b1;
                end else begin
                    store[n_stored] = p;
                    n_stored++;
                end
            end
            if (last) begin
                build_hull();
                n_sets++;
                n_stored = 0;
                ovf      = 1'b0;
            end
        endfunction

        function void check_vertex(vertex_t got);
            vertex_t want;
            if (hull_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected vertex: x=%0d y=%0d last=%0b ovf=%0b",
                             got.x, got.y, got.last, got.ovf);
                return;
            end
            want = hull_q.pop_front();
            n_vertices++;
            if (got.x !== want.x || got.y !== want.y ||
                got.last !== want.last || got.ovf !== want.ovf) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("vertex %0d: exp x=%0d y=%0d last=%0b ovf=%0b,",
                             n_vertices, want.x, want.y, want.last, want.ovf,
                             " got x=%0d y=%0d last=%0b ovf=%0b",
                             got.x, got.y, got.last, got.ovf);
            end
        endfunction
    endclass

    logic            aclk;
    logic            aresetn  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [TD_W-1:0] s_tdata  = '0;    // x_coord, y_coord
    logic            s_tlast  = 1'b0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [TD_W-1:0] m_tdata;          // vertex_x, vertex_y
    logic            m_tlast;
    logic            m_tuser;          // overflow

    bit              no_idle = 1'b0;
    int              n_cycles = 0;
    hull_scoreboard  sb;

    convex_hull_monotone_chain #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("convex_hull_monotone_chain: mismatch");
            $finish;
        end
    end

    // vertex sink with random back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_vertex({m_tdata[COORD_BITS-1:0], m_tdata[2*COORD_BITS-1:COORD_BITS],
                                 m_tlast, m_tuser});
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic point_t pt(int x, int y);
        point_t p;
        p.x = x[COORD_BITS-1:0];
        p.y = y[COORD_BITS-1:0];
        return p;
    endfunction

    function automatic int rand_coord(spread_t spread);
        case (spread)
            SPREAD_TIGHT: return int'($urandom_range(8)) - 4;
            SPREAD_MID:   return int'($urandom_range(2000)) - 1000;
            SPREAD_CORNERS: begin
                case ($urandom_range(3))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            default:      return int'($urandom);
        endcase
    endfunction

    function automatic bit comes_after(point_t a, point_t b);
        return ($signed(a.x) > $signed(b.x)) ||
               (a.x == b.x && $signed(a.y) > $signed(b.y));
    endfunction

    function automatic void make_points(ref point_t pts[$], input int count,
                                        input spread_t spread);
        pts.delete();
        repeat (count)
            pts.insert(pts.size(), pt(rand_coord(spread), rand_coord(spread)));
        for (int i = 1; i < pts.size(); i++) begin
            point_t key;
            int     j;
            key = pts[i];
            j   = i - 1;
            while (j >= 0 && comes_after(pts[j], key)) begin
                pts[j+1] = pts[j];
                j--;
            end
            pts[j+1] = key;
        end
    endfunction

    task automatic send_point(point_t p, bit last);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_point(p, last);
    endtask

    task automatic send_set(point_t pts[$]);
        foreach (pts[i])
            send_point(pts[i], i == pts.size() - 1);
    endtask

    // distinct, x-sorted points spread over the whole range, last one optionally repeated
    task automatic send_capacity_set(int count, bit dup_tail);
        point_t pts[$];
        int     step;
        step = (1 << COORD_BITS) / count;
        for (int i = 0; i < count; i++)
            pts.insert(pts.size(),
                       pt(COORD_MIN + i * step + int'($urandom_range(step - 1)),
                          int'($urandom)));
        if (dup_tail)
            pts.insert(pts.size(), pts[count-1]);
        send_set(pts);
    endtask

    initial begin
        point_t  pts[$];
        point_t  tmp;
        spread_t spread;
        int      set_no;
        int      pick;
        int      count;
        int      i;
        int      j;

        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // lone extreme point
        send_point(pt(COORD_MIN, COORD_MAX), 1'b1);
        // two points
        send_point(pt(0, 0), 1'b0);
        send_point(pt(5, -3), 1'b1);
        // duplicate as final item
        send_point(pt(7, 7), 1'b0);
        send_point(pt(7, 7), 1'b1);
        // triangle
        send_point(pt(0, 0), 1'b0);
        send_point(pt(4, 8), 1'b0);
        send_point(pt(8, 0), 1'b1);
        // collinear run
        send_point(pt(-3, -3), 1'b0);
        send_point(pt(0, 0), 1'b0);
        send_point(pt(2, 2), 1'b0);
        send_point(pt(5, 5), 1'b1);
        // full-range square, interior point and a point on an edge
        send_point(pt(COORD_MIN, COORD_MIN), 1'b0);
        send_point(pt(COORD_MIN, COORD_MAX), 1'b0);
        send_point(pt(0, 0), 1'b0);
        send_point(pt(0, COORD_MAX), 1'b0);
        send_point(pt(COORD_MAX, COORD_MIN), 1'b0);
        send_point(pt(COORD_MAX, COORD_MAX), 1'b1);
        // unsorted
        send_point(pt(5, 0), 1'b0);
        send_point(pt(0, 0), 1'b0);
        send_point(pt(3, 4), 1'b0);
        send_point(pt(1, -2), 1'b1);
        // duplicate final point on a full hull
        send_point(pt(1, 0), 1'b0);
        send_point(pt(2, 5), 1'b0);
        send_point(pt(3, 0), 1'b0);
        send_point(pt(3, 0), 1'b1);

        // store exactly full then a duplicate: no overflow
        send_capacity_set(MAX_POINTS, 1'b1);
        // past capacity
        send_capacity_set(MAX_POINTS + 4, 1'($urandom_range(1)));

        set_no = 0;
        while (sb.n_points < 320) begin
            pick = $urandom_range(99);
            if (pick < 80)
                count = $urandom_range(12, 1);
            else if (pick < 95)
                count = $urandom_range(40, 13);
            else
                count = $urandom_range(70, 60);
            spread = spread_t'($urandom_range(3));
            make_points(pts, count, spread);
            if ($urandom_range(99) < 20) begin
                i = $urandom_range(pts.size() - 1);
                pts.insert(i, pts[i]);
            end
            if ($urandom_range(99) < 10) begin
                i = $urandom_range(pts.size() - 1);
                j = $urandom_range(pts.size() - 1);
                tmp    = pts[i];
                pts[i] = pts[j];
                pts[j] = tmp;
            end
            no_idle = (set_no >= 3 && set_no < 9);
            send_set(pts);
            set_no++;
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (sb.hull_q.size() != 0)
            @(posedge aclk);
        repeat (64) @(posedge aclk);

        $display("%0d points in %0d sets (%0d past capacity), %0d hull vertices compared",
                 sb.n_points, sb.n_sets, sb.n_ovf_sets, sb.n_vertices);
        $display("%0d mismatching vertices", sb.n_errors);
        if (sb.n_errors == 0)
            $display("convex_hull_monotone_chain: match");
        else
            $display("convex_hull_monotone_chain: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/chull_pkg.sv
rtl/chull_ram.sv
rtl/convex_hull_monotone_chain.sv
tb/convex_hull_monotone_chain_tb.sv
